@@ rtl/core/free_page_stack_allocator_top_macros.svh @@
// Assertion macros shared by the free page stack allocator RTL.
// Users must provide clk and rst_n in scope.
`ifndef FREE_PAGE_STACK_ALLOCATOR_TOP_MACROS_SVH
`define FREE_PAGE_STACK_ALLOCATOR_TOP_MACROS_SVH

// Property that must hold in every cycle out of reset.
`define FPSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fpsa_pkg.sv @@
// Package for the free page stack allocator: sizes, codes and word types.
// Used by every module under rtl/core.
`default_nettype none
package fpsa_pkg;

  localparam int PAGE_SHIFT     = 12;
  localparam int MAX_FREE_PAGES = 65536;
  localparam int ADDR_BITS      = 32;

  localparam int PFN_W = ADDR_BITS - PAGE_SHIFT;
  localparam int IDX_W = $clog2(MAX_FREE_PAGES);
  localparam int CNT_W = IDX_W + 1;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIRT_OFFSET = 2'd2;

  localparam logic [CFG_W-1:0] KERNEL_END_RST  = 32'h0000_0000;
  localparam logic [CFG_W-1:0] PHYS_TOP_RST    = 32'h0E00_0000;
  localparam logic [CFG_W-1:0] VIRT_OFFSET_RST = 32'h8000_0000;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic MODE_FREE  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [ADDR_BITS-1:0] page_address;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] granted_address;
    logic [1:0]           status;
    logic [CNT_W-1:0]     free_count;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] kernel_end;
    logic [ADDR_BITS-1:0] phys_top;
    logic [ADDR_BITS-1:0] virt_offset;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [PFN_W-1:0] wdata;
  } ram_req_t;

endpackage
`default_nettype wire

@@ rtl/core/fpsa_cfg_regs.sv @@
// Configuration registers: kernel end, physical top, virtual offset.
// Depends on fpsa_pkg.
`default_nettype none
module fpsa_cfg_regs
  import fpsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  logic [ADDR_BITS-1:0] kernel_end_r;
  logic [ADDR_BITS-1:0] phys_top_r;
  logic [ADDR_BITS-1:0] virt_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_end_r  <= ADDR_BITS'(KERNEL_END_RST);
      phys_top_r    <= ADDR_BITS'(PHYS_TOP_RST);
      virt_offset_r <= ADDR_BITS'(VIRT_OFFSET_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_END:  kernel_end_r  <= ADDR_BITS'(cfg_wdata);
        CFG_PHYS_TOP:    phys_top_r    <= ADDR_BITS'(cfg_wdata);
        CFG_VIRT_OFFSET: virt_offset_r <= ADDR_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign cfg.kernel_end  = kernel_end_r;
  assign cfg.phys_top    = phys_top_r;
  assign cfg.virt_offset = virt_offset_r;

endmodule
`default_nettype wire

@@ rtl/core/fpsa_frame_ram.sv @@
// Frame number store: one write or one read per cycle, registered read data.
// Depends on fpsa_pkg.
`default_nettype none
module fpsa_frame_ram
  import fpsa_pkg::*;
(
  input  wire logic             clk,
  input  ram_req_t              req,
  output logic      [PFN_W-1:0] rd_data
);

  logic [PFN_W-1:0] mem [MAX_FREE_PAGES];
  logic [PFN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/core/fpsa_stack_ctrl.sv @@
// Stack control: address check, top pointer, RAM requests and result stages.
// Depends on fpsa_pkg and the assertion macros header.
`default_nettype none
`include "free_page_stack_allocator_top_macros.svh"
module fpsa_stack_ctrl
  import fpsa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  cfg_t                  cfg,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data,
  output ram_req_t              ram_req,
  input  wire logic [PFN_W-1:0] rd_data
);

  logic [CNT_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] top_m1;
  logic             s1_valid_r;
  logic             s1_grant_r;
  logic [1:0]       s1_status_r;
  logic [CNT_W-1:0] s1_count_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic                 adv, acc;
  logic                 full, empty;
  logic                 addr_ok;
  logic [ADDR_BITS-1:0] pa;
  logic                 push_ok, pop_ok;
  logic [1:0]           status;

  // advance the result stage when the output register is free or drains
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign acc      = in_valid && !in_stall;

  assign full   = top_r[IDX_W];
  assign empty  = (top_r == '0);
  assign top_m1 = top_r - CNT_W'(1);

  assign pa      = in_data.page_address - cfg.virt_offset;
  assign addr_ok = (in_data.page_address[PAGE_SHIFT-1:0] == '0)
                && (in_data.page_address >= cfg.kernel_end)
                && (pa < cfg.phys_top);

  assign push_ok = acc && (in_data.mode == MODE_FREE) && addr_ok && !full;
  assign pop_ok  = acc && (in_data.mode == MODE_ALLOC) && !empty;

  always_comb begin
    if (in_data.mode == MODE_ALLOC) begin
      status = empty ? ST_EMPTY : ST_OK;
    end else if (!addr_ok) begin
      status = ST_BAD_ADDR;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    top_nxt = top_r;
    if (push_ok) begin
      top_nxt = top_r + CNT_W'(1);
    end else if (pop_ok) begin
      top_nxt = top_m1;
    end
  end

  // a push writes at the top, a pop reads the entry below it
  assign ram_req.we    = push_ok;
  assign ram_req.re    = pop_ok;
  assign ram_req.addr  = push_ok ? top_r[IDX_W-1:0] : top_m1[IDX_W-1:0];
  assign ram_req.wdata = in_data.page_address[ADDR_BITS-1:PAGE_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      top_r <= top_nxt;
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_grant_r  <= pop_ok;
      s1_status_r <= status;
      s1_count_r  <= top_nxt;
    end
  end

  // read data is valid in the stage after the pop issued
  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_data_r.granted_address <= s1_grant_r ? {rd_data, PAGE_SHIFT'(0)} : '0;
      out_data_r.status          <= s1_status_r;
      out_data_r.free_count      <= s1_count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FPSA_ASSERT(a_top_bound, top_r <= CNT_W'(MAX_FREE_PAGES), "top pointer beyond capacity")
  `FPSA_ASSERT_NEXT(a_push_inc, push_ok, top_r == $past(top_r) + CNT_W'(1), "push lost count")
  `FPSA_ASSERT(a_empty_zero, !out_valid_r || out_data_r.status != ST_EMPTY || out_data_r.free_count == '0, "empty status with pages held")
  `FPSA_ASSERT(a_fail_no_grant, !out_valid_r || out_data_r.status == ST_OK || out_data_r.granted_address == '0, "address granted on failure")

endmodule
`default_nettype wire

@@ rtl/core/free_page_stack_allocator_top.sv @@
// Top level of the free page stack allocator.
// Depends on fpsa_pkg, fpsa_cfg_regs, fpsa_frame_ram and fpsa_stack_ctrl.
//
//  channel  ports                           word
//  in       in_valid / in_stall / in_data   mode, page_address
//  out      out_valid / out_stall / out_data granted_address, status, free_count
//  cfg      cfg_we / cfg_index / cfg_wdata  kernel_end, phys_top, virt_offset
//
// One word per cycle is accepted while the result stage can advance; its result is
// registered by the frame RAM read beside stage one, then by the output register.
// Push and pop update the top pointer at accept, so back-to-back words
// never collide on the RAM. Reset clears the count; the RAM is not cleared.
// A stalled output holds its word; one more word may wait behind it.
`default_nettype none
module free_page_stack_allocator_top
  import fpsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  in_word_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t             cfg;
  ram_req_t         ram_req;
  logic [PFN_W-1:0] rd_data;

  fpsa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpsa_frame_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  fpsa_stack_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ram_req   (ram_req),
    .rd_data   (rd_data)
  );

endmodule
`default_nettype wire

@@ bench/free_page_stack_allocator_top_tb.sv @@
// Testbench for free_page_stack_allocator_top: directed and random free/alloc words.
// Checks every result word against a LIFO page-store predictor; needs fpsa_pkg.
`default_nettype none
module free_page_stack_allocator_top_tb;
  import fpsa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [31:0] PAGE_BYTES = 32'd1 << PAGE_SHIFT;
  localparam logic [31:0] PAGE_MASK  = PAGE_BYTES - 32'd1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STACK_FILL = 48;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // predictor state
  logic [31:0]      kernel_end_m  = KERNEL_END_RST;
  logic [31:0]      phys_top_m    = PHYS_TOP_RST;
  logic [31:0]      virt_offset_m = VIRT_OFFSET_RST;
  logic [PFN_W-1:0] held_pfns [MAX_FREE_PAGES];
  int               held_count = 0;
  out_word_t        awaited_results[$];

  int snd_max = 19;
  int rcv_max = 19;
  int stall_left = 0;
  int idle_cycles = 0;
  int error_count = 0;
  int words_sent = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  free_page_stack_allocator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Push a valid page or pop the newest one; return the result word.
  function automatic out_word_t allocator_outcome(input in_word_t w);
    out_word_t   r;
    logic [31:0] pa;
    r  = '0;
    pa = w.page_address - virt_offset_m;
    if (w.mode == MODE_FREE) begin
      if ((w.page_address & PAGE_MASK) != 0 || w.page_address < kernel_end_m ||
          pa >= phys_top_m) begin
        r.status = ST_BAD_ADDR;
      end else if (held_count >= MAX_FREE_PAGES) begin
        r.status = ST_FULL;
      end else begin
        held_pfns[held_count] = w.page_address[ADDR_BITS-1:PAGE_SHIFT];
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      held_count--;
      r.granted_address = {held_pfns[held_count], {PAGE_SHIFT{1'b0}}};
    end
    r.free_count = held_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_good_page();
    logic [31:0] pa;
    logic [31:0] va;
    if (phys_top_m == 0) return $urandom;
    for (int k = 0; k < 16; k++) begin
      case (k % 3)
        0: pa = $urandom % phys_top_m;
        1: pa = kernel_end_m - virt_offset_m + PAGE_MASK + PAGE_BYTES * $urandom_range(0, 255);
        default: pa = phys_top_m - 32'd1 - PAGE_BYTES * $urandom_range(0, 3);
      endcase
      pa = pa & ~PAGE_MASK;
      va = pa + virt_offset_m;
      if (va >= kernel_end_m && pa < phys_top_m && (va & PAGE_MASK) == 0) return va;
    end
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_bad_page();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return pick_good_page() | $urandom_range(1, PAGE_MASK);
      2: return (kernel_end_m & ~PAGE_MASK) - PAGE_BYTES * $urandom_range(1, 4);
      default: return ((phys_top_m + PAGE_MASK) & ~PAGE_MASK) + virt_offset_m +
                      PAGE_BYTES * $urandom_range(0, 3);
    endcase
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Hold the word until accepted, then log its expected result.
  task automatic send_word(input logic mode, input logic [31:0] addr);
    int       gap;
    in_word_t w;
    gap = (snd_max > 0) ? $urandom_range(0, snd_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.mode = mode;
    w.page_address = addr;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(allocator_outcome(w));
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] ke, input logic [31:0] pt,
                           input logic [31:0] vo, input bit poke_spare);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KERNEL_END;
    cfg_wdata <= ke;
    @(posedge clk);
    kernel_end_m = ke;
    cfg_index <= CFG_PHYS_TOP;
    cfg_wdata <= pt;
    @(posedge clk);
    phys_top_m = pt;
    cfg_index <= CFG_VIRT_OFFSET;
    cfg_wdata <= vo;
    @(posedge clk);
    virt_offset_m = vo;
    // an unused index must leave every register alone
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_free_checks();
    send_word(MODE_ALLOC, 32'hFFFF_FFFF);
    send_word(MODE_FREE, 32'h8000_0000);
    send_word(MODE_FREE, 32'h8DFF_F000);
    send_word(MODE_FREE, 32'h8E00_0000);
    send_word(MODE_FREE, 32'h8000_0800);
    send_word(MODE_FREE, 32'h7FFF_F000);
    send_word(MODE_FREE, 32'hFFFF_FFFF);
    send_word(MODE_FREE, 32'h0000_0000);
    send_word(MODE_ALLOC, 32'h0000_0000);
    send_word(MODE_ALLOC, $urandom);
    send_word(MODE_ALLOC, $urandom);
    load_regs(32'h8010_0000, 32'h0E00_0000, 32'h8000_0000, 1'b1);
    send_word(MODE_FREE, 32'h800F_F000);
    send_word(MODE_FREE, 32'h8010_0000);
    send_word(MODE_ALLOC, $urandom);
    load_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_word(MODE_FREE, 32'hFFFF_F000);
    send_word(MODE_FREE, 32'h0000_0000);
    send_word(MODE_ALLOC, $urandom);
    send_word(MODE_ALLOC, $urandom);
  endtask

  // Build a deep stack, try bad frees on top of it, then drain it past empty.
  task automatic test_stack_depth();
    load_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    snd_max = 0;
    rcv_max <= 0;
    while (held_count < STACK_FILL - 16) send_word(MODE_FREE, $urandom & ~PAGE_MASK);
    snd_max = 19;
    rcv_max <= 19;
    while (held_count < STACK_FILL) send_word(MODE_FREE, $urandom & ~PAGE_MASK);
    send_word(MODE_FREE, 32'h0000_0FFF);
    send_word(MODE_FREE, 32'hFFFF_F001);
    repeat (8) send_word(MODE_ALLOC, $urandom);
    snd_max = 0;
    rcv_max <= 0;
    while (held_count > 16) send_word(MODE_ALLOC, $urandom);
    snd_max = 19;
    rcv_max <= 19;
    while (held_count > 0) send_word(MODE_ALLOC, $urandom);
    send_word(MODE_ALLOC, $urandom);
  endtask

  task automatic test_random_traffic(input int n_words, input logic [31:0] ke,
                                     input logic [31:0] pt, input logic [31:0] vo,
                                     input int snd_idle, input int rcv_idle);
    int roll;
    load_regs(ke, pt, vo, 1'b0);
    snd_max = snd_idle;
    rcv_max <= rcv_idle;
    repeat (n_words) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) send_word(MODE_FREE, pick_good_page());
      else if (roll < 60) send_word(MODE_FREE, pick_bad_page());
      else send_word(MODE_ALLOC, $urandom);
    end
  endtask

  task automatic test_random_registers(input int n_words);
    logic [31:0] vo;
    logic [31:0] pt;
    vo = $urandom & ~PAGE_MASK;
    pt = $urandom;
    test_random_traffic(n_words, vo + ($urandom_range(0, 3) * (pt >> 2)), pt, vo,
                        $urandom_range(0, 1) * 19, $urandom_range(0, 1) * 19);
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d words: %0d ok, %0d bad address, %0d empty, %0d full",
             words_sent, status_seen[ST_OK], status_seen[ST_BAD_ADDR],
             status_seen[ST_EMPTY], status_seen[ST_FULL]);
    $display("stack built to %0d pages and drained past empty; %0d mismatches", STACK_FILL,
             error_count);
    if (error_count == 0) begin
      $display("** free_page_stack_allocator_top: PASSED **");
    end else begin
      $display("** free_page_stack_allocator_top: FAILED **");
    end
    $finish;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_free_checks();
    test_stack_depth();
    test_random_traffic(300, 32'h8010_0000, 32'h0E00_0000, 32'h8000_0000, 19, 19);
    test_random_traffic(300, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 0, 19);
    test_random_traffic(250, 32'h0000_1000, 32'h0010_0000, 32'hFFFF_F000, 19, 0);
    test_random_traffic(100, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0);
    test_random_registers(200);
    test_random_registers(200);
    test_random_registers(200);
    finish_run();
  end

  // Check each accepted result word, then draw the next stall.
  always @(posedge clk) begin : result_side
    out_word_t   want;
    int unsigned n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          flag_error("unexpected word", out_data.granted_address, 32'd0);
        end else begin
          want = awaited_results.pop_front();
          status_seen[want.status]++;
          if (out_data.granted_address !== want.granted_address) begin
            flag_error("granted_address", out_data.granted_address, want.granted_address);
          end
          if (out_data.status !== want.status) begin
            flag_error("status", 32'(out_data.status), 32'(want.status));
          end
          if (out_data.free_count !== want.free_count) begin
            flag_error("free_count", 32'(out_data.free_count), 32'(want.free_count));
          end
        end
        n = (rcv_max > 0) ? $urandom_range(0, rcv_max) : 0;
        stall_left <= n;
        out_stall  <= (n != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_stall  <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** free_page_stack_allocator_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire
